@@ hw/rtl/pkf_pkg.sv @@
// Package for the pressure key press filter.
// Holds the key count, the per-key thresholds and the shared types.
// Depends on nothing.
package pkf_pkg;

   localparam int KEY_COUNT = 5;
   localparam int FORCE_WIDTH = 7;

   typedef logic [FORCE_WIDTH-1:0] force_type;
   typedef force_type [KEY_COUNT-1:0] force_array_type;
   typedef logic [KEY_COUNT-1:0] key_mask_type;

   localparam force_type FULL_FORCE = 7'h7F;

   localparam force_array_type LEVEL_THRESHOLD = {7'd15, 7'd15, 7'd15, 7'd10, 7'd10};
   localparam force_array_type DELTA_THRESHOLD = {7'd5, 7'd5, 7'd4, 7'd4, 7'd3};

   typedef struct packed {
      force_array_type forces;
      force_array_type filtered;
      key_mask_type press_mask;
      key_mask_type release_mask;
   } result_type;

endpackage

@@ hw/rtl/pkf_core.sv @@
// Combinational filter for one sample: forces, deltas, suppression among
// sensors 2 to 4, pressed decisions and key change masks.
// Depends on pkf_pkg.
module pkf_core (
   input  pkf_pkg::force_array_type levels,
   input  pkf_pkg::force_array_type previous_forces,
   input  logic                     previous_valid,
   input  pkf_pkg::key_mask_type    key_down,
   output pkf_pkg::result_type      result,
   output pkf_pkg::key_mask_type    pressed
);

   pkf_pkg::force_array_type forces;
   logic signed [pkf_pkg::FORCE_WIDTH:0] delta [pkf_pkg::KEY_COUNT];
   logic signed [pkf_pkg::FORCE_WIDTH:0] delta_limit [pkf_pkg::KEY_COUNT];
   pkf_pkg::force_type excess [pkf_pkg::KEY_COUNT];
   pkf_pkg::key_mask_type above_delta;
   pkf_pkg::key_mask_type blocked;

   always_comb begin
      for (int i = 0; i < pkf_pkg::KEY_COUNT; i++) begin
         forces[i] = pkf_pkg::FULL_FORCE - levels[i];
         delta_limit[i] = $signed({1'b0, pkf_pkg::DELTA_THRESHOLD[i]});
         if (previous_valid) begin
            delta[i] = $signed({1'b0, forces[i]}) - $signed({1'b0, previous_forces[i]});
         end else begin
            delta[i] = '0;
         end
         above_delta[i] = delta[i] > delta_limit[i];
         if (above_delta[i]) begin
            excess[i] = delta[i][pkf_pkg::FORCE_WIDTH-1:0] - pkf_pkg::DELTA_THRESHOLD[i];
         end else begin
            excess[i] = '0;
         end
      end

      // Only the sensor with the largest excess among 2 to 4 stays free; ties favour
      // the higher sensor.
      blocked = 5'b11100;
      if (excess[4] >= excess[3] && excess[4] >= excess[2]) begin
         blocked[4] = 1'b0;
      end else if (excess[3] >= excess[2]) begin
         blocked[3] = 1'b0;
      end else begin
         blocked[2] = 1'b0;
      end

      for (int i = 0; i < pkf_pkg::KEY_COUNT; i++) begin
         pressed[i] = above_delta[i] && !blocked[i] && forces[i] > pkf_pkg::LEVEL_THRESHOLD[i];
         result.forces[i] = forces[i];
         result.filtered[i] = pressed[i] ? forces[i] : '0;
      end
      result.press_mask = pressed & ~key_down;
      result.release_mask = ~pressed & key_down;
   end

endmodule

@@ hw/rtl/pressure_key_press_filter_unit.sv @@
// Top level of the pressure key press filter: input register, filter logic,
// result register and the sample history.
// Depends on pkf_pkg and pkf_core.
//
// The unit takes one sample of five sensor levels per clock cycle while the result
// side is not stalled, and returns one result item per sample, in order. An accepted
// sample waits in the input register while the filter logic works on it, and its
// result is written to the result register once that register is free or being taken.
// The history of forces and key states advances
// as each sample moves into the result register, so a stalled result side
// holds the pipeline without losing or repeating an item.
module pressure_key_press_filter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [6:0] req_level_0,
   input  logic [6:0] req_level_1,
   input  logic [6:0] req_level_2,
   input  logic [6:0] req_level_3,
   input  logic [6:0] req_level_4,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_force_0,
   output logic [6:0] rsp_force_1,
   output logic [6:0] rsp_force_2,
   output logic [6:0] rsp_force_3,
   output logic [6:0] rsp_force_4,
   output logic [6:0] rsp_filtered_0,
   output logic [6:0] rsp_filtered_1,
   output logic [6:0] rsp_filtered_2,
   output logic [6:0] rsp_filtered_3,
   output logic [6:0] rsp_filtered_4,
   output logic [4:0] rsp_press_mask,
   output logic [4:0] rsp_release_mask
);

   logic                     in_valid_ff;
   pkf_pkg::force_array_type levels_ff;
   logic                     out_valid_ff;
   pkf_pkg::result_type      result_ff;
   pkf_pkg::force_array_type previous_forces_ff;
   logic                     previous_valid_ff;
   pkf_pkg::key_mask_type    key_down_ff;

   pkf_pkg::result_type      result_in;
   pkf_pkg::key_mask_type    key_down_in;
   logic                     advance;
   logic                     accept;

   pkf_core core (
      .levels          (levels_ff),
      .previous_forces (previous_forces_ff),
      .previous_valid  (previous_valid_ff),
      .key_down        (key_down_ff),
      .result          (result_in),
      .pressed         (key_down_in)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         previous_forces_ff <= '0;
         previous_valid_ff <= 1'b0;
         key_down_ff <= '0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            previous_forces_ff <= result_in.forces;
            previous_valid_ff <= 1'b1;
            key_down_ff <= key_down_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         levels_ff <= {req_level_4, req_level_3, req_level_2, req_level_1, req_level_0};
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_force_0 = result_ff.forces[0];
   assign rsp_force_1 = result_ff.forces[1];
   assign rsp_force_2 = result_ff.forces[2];
   assign rsp_force_3 = result_ff.forces[3];
   assign rsp_force_4 = result_ff.forces[4];
   assign rsp_filtered_0 = result_ff.filtered[0];
   assign rsp_filtered_1 = result_ff.filtered[1];
   assign rsp_filtered_2 = result_ff.filtered[2];
   assign rsp_filtered_3 = result_ff.filtered[3];
   assign rsp_filtered_4 = result_ff.filtered[4];
   assign rsp_press_mask = result_ff.press_mask;
   assign rsp_release_mask = result_ff.release_mask;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pressure key press filter unit.
// Drives five-sensor samples over valid/ready and checks every result item against
// a local model of the filter. Depends on pkf_pkg and pressure_key_press_filter_unit.
module testbench;

   localparam int RUN_LIMIT = 100000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [6:0] req_level_0, req_level_1, req_level_2, req_level_3, req_level_4;
   logic rsp_valid;
   logic rsp_ready;
   logic [6:0] rsp_force_0, rsp_force_1, rsp_force_2, rsp_force_3, rsp_force_4;
   logic [6:0] rsp_filtered_0, rsp_filtered_1, rsp_filtered_2, rsp_filtered_3;
   logic [6:0] rsp_filtered_4;
   logic [4:0] rsp_press_mask, rsp_release_mask;

   pkf_pkg::force_array_type prev_pressure;
   pkf_pkg::key_mask_type key_held;
   logic sample_seen;
   pkf_pkg::result_type pending_results[$];
   pkf_pkg::force_array_type last_levels;

   int errors;
   int cycles;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int hold_left;

   pressure_key_press_filter_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_level_0(req_level_0),
      .req_level_1(req_level_1),
      .req_level_2(req_level_2),
      .req_level_3(req_level_3),
      .req_level_4(req_level_4),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_force_0(rsp_force_0),
      .rsp_force_1(rsp_force_1),
      .rsp_force_2(rsp_force_2),
      .rsp_force_3(rsp_force_3),
      .rsp_force_4(rsp_force_4),
      .rsp_filtered_0(rsp_filtered_0),
      .rsp_filtered_1(rsp_filtered_1),
      .rsp_filtered_2(rsp_filtered_2),
      .rsp_filtered_3(rsp_filtered_3),
      .rsp_filtered_4(rsp_filtered_4),
      .rsp_press_mask(rsp_press_mask),
      .rsp_release_mask(rsp_release_mask)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Computes the result for one sample and advances the filter history.
   function automatic pkf_pkg::result_type filter_sample(
         input pkf_pkg::force_array_type levels);
      pkf_pkg::result_type r;
      int delta [pkf_pkg::KEY_COUNT];
      int e2, e3, e4, top, winner;
      logic pressed;
      r = '0;
      for (int i = 0; i < pkf_pkg::KEY_COUNT; i++) begin
         r.forces[i] = pkf_pkg::FULL_FORCE - levels[i];
         delta[i] = sample_seen ? int'(r.forces[i]) - int'(prev_pressure[i]) : 0;
      end
      e2 = delta[2] > int'(pkf_pkg::DELTA_THRESHOLD[2]) ?
           delta[2] - int'(pkf_pkg::DELTA_THRESHOLD[2]) : 0;
      e3 = delta[3] > int'(pkf_pkg::DELTA_THRESHOLD[3]) ?
           delta[3] - int'(pkf_pkg::DELTA_THRESHOLD[3]) : 0;
      e4 = delta[4] > int'(pkf_pkg::DELTA_THRESHOLD[4]) ?
           delta[4] - int'(pkf_pkg::DELTA_THRESHOLD[4]) : 0;
      top = e2;
      if (e3 > top) top = e3;
      if (e4 > top) top = e4;
      winner = (top == e4) ? 4 : (top == e3) ? 3 : 2;
      for (int i = 0; i < pkf_pkg::KEY_COUNT; i++) begin
         pressed = delta[i] > int'(pkf_pkg::DELTA_THRESHOLD[i]) && (i < 2 || i == winner)
                   && r.forces[i] > pkf_pkg::LEVEL_THRESHOLD[i];
         if (pressed) r.filtered[i] = r.forces[i];
         r.press_mask[i] = pressed && !key_held[i];
         r.release_mask[i] = !pressed && key_held[i];
         key_held[i] = pressed;
         prev_pressure[i] = r.forces[i];
      end
      sample_seen = 1'b1;
      return r;
   endfunction

   function automatic void report(input string what, input int want, input int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endfunction

   // Both handshakes are observed at the falling edge; the values seen there are the
   // ones sampled by the next rising edge.
   always @(negedge clock) begin
      pkf_pkg::result_type want;
      pkf_pkg::force_array_type got_forces, got_filtered;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_results.push_back(filter_sample({req_level_4, req_level_3,
                                                     req_level_2, req_level_1,
                                                     req_level_0}));
         if (rsp_valid && rsp_ready) begin
            got_forces = {rsp_force_4, rsp_force_3, rsp_force_2, rsp_force_1, rsp_force_0};
            got_filtered = {rsp_filtered_4, rsp_filtered_3, rsp_filtered_2,
                            rsp_filtered_1, rsp_filtered_0};
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: result item with none expected", $time);
            end else begin
               want = pending_results.pop_front();
               for (int i = 0; i < pkf_pkg::KEY_COUNT; i++) begin
                  if (got_forces[i] !== want.forces[i])
                     report($sformatf("force %0d", i), int'(want.forces[i]),
                            int'(got_forces[i]));
                  if (got_filtered[i] !== want.filtered[i])
                     report($sformatf("filtered %0d", i), int'(want.filtered[i]),
                            int'(got_filtered[i]));
               end
               if (rsp_press_mask !== want.press_mask)
                  report("press mask", int'(want.press_mask), int'(rsp_press_mask));
               if (rsp_release_mask !== want.release_mask)
                  report("release mask", int'(want.release_mask), int'(rsp_release_mask));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_sample(input pkf_pkg::force_array_type levels);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_level_0 <= levels[0];
      req_level_1 <= levels[1];
      req_level_2 <= levels[2];
      req_level_3 <= levels[3];
      req_level_4 <= levels[4];
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      last_levels = levels;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Samples are written as forces, key 4 first; inverting a force gives its level.
   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_sample(~{7'd127, 7'd127, 7'd127, 7'd127, 7'd127});
      send_sample(~{7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
      send_sample(~{7'd127, 7'd127, 7'd127, 7'd127, 7'd127});
      send_sample(~{7'd127, 7'd127, 7'd127, 7'd127, 7'd127});
      send_sample(~{7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
      send_sample(~{7'd25, 7'd25, 7'd24, 7'd5, 7'd3});
      send_sample(~{7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
      send_sample(~{7'd20, 7'd25, 7'd24, 7'd11, 7'd4});
      send_sample(~{7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
      send_sample(~{7'd5, 7'd5, 7'd4, 7'd4, 7'd10});
      send_sample(~{7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
      send_sample(~{7'd0, 7'd0, 7'd16, 7'd11, 7'd11});
      send_sample(~{7'd0, 7'd127, 7'd21, 7'd15, 7'd14});
      send_sample(~{7'd0, 7'd0, 7'd0, 7'd0, 7'd0});
      send_sample({7'h55, 7'h2A, 7'h55, 7'h2A, 7'h55});
      send_sample({7'h2A, 7'h55, 7'h2A, 7'h55, 7'h2A});
      wait_results_drained();
   endtask

   // Most levels drift a little from the last sample's level so that deltas land near the
   // thresholds; the rest are drawn at random over the whole range.
   task automatic test_random_stream(input int count, input int s_pct, input int r_pct);
      pkf_pkg::force_array_type levels;
      int step;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < pkf_pkg::KEY_COUNT; i++) begin
            if ($urandom_range(99) < 40) begin
               levels[i] = 7'($urandom_range(127));
            end else begin
               step = int'(last_levels[i]) + int'($urandom_range(20)) - 10;
               levels[i] = step < 0 ? 7'd0 : step > 127 ? 7'd127 : step[6:0];
            end
         end
         send_sample(levels);
      end
      wait_results_drained();
   endtask

   task automatic test_stall_fill();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(negedge clock);
      hold_request = 300;
      @(posedge clock);
      for (int n = 0; n < 40; n++)
         send_sample({7'($urandom_range(127)), 7'($urandom_range(127)),
                      7'($urandom_range(127)), 7'($urandom_range(127)),
                      7'($urandom_range(127))});
      wait_results_drained();
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_level_0 <= '0;
      req_level_1 <= '0;
      req_level_2 <= '0;
      req_level_3 <= '0;
      req_level_4 <= '0;
      rsp_ready <= 1'b0;
      prev_pressure = '0;
      key_held = '0;
      sample_seen = 1'b0;
      last_levels = '0;
      errors = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 0;
      hold_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_stream(600, 9, 73);
      test_random_stream(600, 73, 9);
      test_stall_fill();
      test_random_stream(500, 0, 0);

      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t: %0d result items never arrived", $time, pending_results.size());
      end
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/pkf_pkg.sv
hw/rtl/pkf_core.sv
hw/rtl/pressure_key_press_filter_unit.sv
verif/testbench.sv
